// ----- sv/caet_pkg.sv -----
// shared types, constants and saturating fixed-point helpers for the escape-time unit
`timescale 1ns / 1ps
`default_nettype none

package caet_pkg;

  // number format of the data path
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 26;
  localparam int IN_W       = 32;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int WIDE_W     = (DATA_WIDTH > IN_W) ? DATA_WIDTH : IN_W;

  // configuration and result widths
  localparam int CNT_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_MODE = CFG_IDX_W'(1);

  // register reset values
  localparam logic [CNT_W-1:0]  MAX_ITER_RST = CNT_W'(50);
  localparam logic [MODE_W-1:0] ESC_MODE_RST = MODE_W'(0);

  // escape test codes, the unused code runs as the sum test
  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] fx_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;

  localparam fx_t FX_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fx_t FX_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam fx_t FX_FOUR = fx_t'(64'd4 << FRAC_BITS);

  // value with its saturation flag
  typedef struct packed {
    fx_t  val;
    logic sat;
  } fx_res_t;

  // one point as it sits in the queue
  typedef struct packed {
    fx_t  cr;
    fx_t  ci;
    logic skip;
  } caet_item_t;

  // iteration sequencer phases
  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_ABS,
    ENG_SQ,
    ENG_CUBE,
    ENG_MIX,
    ENG_SUM,
    ENG_IMAG,
    ENG_SQI,
    ENG_TEST,
    ENG_EMIT
  } caet_state_t;

  // saturating add
  function automatic fx_res_t fx_add(fx_t a, fx_t b);
    logic [DATA_WIDTH:0] s;
    fx_res_t             r;
    s     = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    r.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
    if (r.sat) begin
      r.val = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // saturating subtract
  function automatic fx_res_t fx_sub(fx_t a, fx_t b);
    logic [DATA_WIDTH:0] s;
    fx_res_t             r;
    s     = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    r.sat = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
    if (r.sat) begin
      r.val = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // absolute value, most negative value clips to the largest positive one
  function automatic fx_res_t fx_abs(fx_t a);
    fx_res_t r;
    r.sat = (a == FX_MIN);
    if (r.sat) begin
      r.val = FX_MAX;
    end else begin
      r.val = a[DATA_WIDTH-1] ? -a : a;
    end
    return r;
  endfunction

  // sign-magnitude product, truncated toward zero, then saturated
  function automatic fx_res_t fx_mul(fx_t a, fx_t b);
    mag_t              ma;
    mag_t              mb;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] lim;
    logic              neg;
    fx_res_t           r;
    ma   = a[DATA_WIDTH-1] ? mag_t'(-a) : mag_t'(a);
    mb   = b[DATA_WIDTH-1] ? mag_t'(-b) : mag_t'(b);
    prod = PROD_W'(ma) * PROD_W'(mb);
    q    = prod >> FRAC_BITS;
    neg  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    lim  = PROD_W'(FX_MAX) + PROD_W'(neg);
    r.sat = (q > lim);
    if (r.sat) begin
      r.val = neg ? FX_MIN : FX_MAX;
    end else begin
      r.val = neg ? -fx_t'(q[DATA_WIDTH-1:0]) : fx_t'(q[DATA_WIDTH-1:0]);
    end
    return r;
  endfunction

  // bring a 32-bit input into the data path range
  function automatic fx_t fx_load(logic signed [IN_W-1:0] v);
    logic signed [WIDE_W-1:0] x;
    fx_t                      r;
    x = WIDE_W'(v);
    if (x > WIDE_W'(FX_MAX)) begin
      r = FX_MAX;
    end else if (x < WIDE_W'(FX_MIN)) begin
      r = FX_MIN;
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/caet_point_if.sv -----
// point request channel: valid, ready and the complex point
`timescale 1ns / 1ps
`default_nettype none

interface caet_point_if import caet_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] cr;
  logic signed [IN_W-1:0] ci;

  modport source (output valid, output cr, output ci, input ready);
  modport sink   (input valid, input cr, input ci, output ready);
endinterface

`default_nettype wire

// ----- sv/caet_result_if.sv -----
// result request channel: valid, ready, escape flag and iteration index
`timescale 1ns / 1ps
`default_nettype none

interface caet_result_if import caet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             escaped;
  logic [CNT_W-1:0] iter_count;

  modport source (output valid, output escaped, output iter_count, input ready);
  modport sink   (input valid, input escaped, input iter_count, output ready);
endinterface

`default_nettype wire

// ----- sv/caet_front.sv -----
// front end: takes point requests, clamps them and flags zero-iteration work
`timescale 1ns / 1ps
`default_nettype none

module caet_front import caet_pkg::*; (
  caet_point_if.sink       in_ch,
  input  logic [CNT_W-1:0] iter_limit,
  input  logic             q_full,
  output logic             push,
  output caet_item_t       push_item
);

  // take a request whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // classify: clamp into range, mark points that need no iteration
  always_comb begin
    push_item.cr   = fx_load(in_ch.cr);
    push_item.ci   = fx_load(in_ch.ci);
    push_item.skip = (iter_limit == '0);
  end

endmodule

`default_nettype wire

// ----- sv/caet_queue.sv -----
// two-entry queue between the front end and the iteration engine
`timescale 1ns / 1ps
`default_nettype none

module caet_queue import caet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  caet_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output caet_item_t head_item
);

  caet_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/caet_engine.sv -----
// back end: eight-phase iteration sequencer on three shared multipliers
`timescale 1ns / 1ps
`default_nettype none

module caet_engine import caet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  iter_limit,
  input  logic [MODE_W-1:0] esc_mode,
  input  logic              q_valid,
  input  caet_item_t        q_item,
  output logic              q_pop,
  caet_result_if.source     out_ch
);

  caet_state_t      state_r;
  caet_state_t      state_nxt;
  logic [CNT_W-1:0] iter_r;
  logic [CNT_W-1:0] iter_nxt;
  logic             sat_r;
  logic             sat_nxt;

  // point and iteration values
  fx_t cr_r, cr_nxt, ci_r, ci_nxt;
  fx_t zr_r, zr_nxt, zi_r, zi_nxt;
  fx_t a_r, a_nxt, b_r, b_nxt;
  fx_t a2_r, a2_nxt, b2_r, b2_nxt;
  fx_t ax3_r, ax3_nxt, a2x3_r, a2x3_nxt;
  fx_t a3_r, a3_nxt, p_r, p_nxt, r_r, r_nxt, q_r, q_nxt;
  fx_t re_r, re_nxt, im_r, im_nxt;
  fx_t sr_r, sr_nxt, si_r, si_nxt;

  // pending result and output register
  logic             res_esc_r;
  logic             res_esc_nxt;
  logic [CNT_W-1:0] res_cnt_r;
  logic [CNT_W-1:0] res_cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_esc_r;
  logic             out_esc_nxt;
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] out_cnt_nxt;

  // shared multiplier operands and results
  fx_t     m0_a, m0_b, m1_a, m1_b, m2_a, m2_b;
  fx_res_t mul0;
  fx_res_t mul1;
  fx_res_t mul2;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.escaped    = out_esc_r;
  assign out_ch.iter_count = out_cnt_r;

  // operand select per phase
  always_comb begin
    m0_a = '0;
    m0_b = '0;
    m1_a = '0;
    m1_b = '0;
    m2_a = '0;
    m2_b = '0;
    case (state_r)
      ENG_SQ: begin
        m0_a = a_r;
        m0_b = a_r;
        m1_a = b_r;
        m1_b = b_r;
      end
      ENG_CUBE: begin
        m0_a = a2_r;
        m0_b = a_r;
        m1_a = ax3_r;
        m1_b = b2_r;
        m2_a = b2_r;
        m2_b = b_r;
      end
      ENG_MIX: begin
        m0_a = a2x3_r;
        m0_b = b_r;
      end
      ENG_IMAG: begin
        m0_a = zr_r;
        m0_b = zr_r;
      end
      ENG_SQI: begin
        m0_a = zi_r;
        m0_b = zi_r;
      end
      ENG_TEST: begin
        m0_a = sr_r;
        m0_b = si_r;
      end
      default: begin
      end
    endcase
  end

  assign mul0 = fx_mul(m0_a, m0_b);
  assign mul1 = fx_mul(m1_a, m1_b);
  assign mul2 = fx_mul(m2_a, m2_b);

  // sequencer next state and data path
  always_comb begin
    fx_res_t t0;
    fx_res_t t1;
    fx_res_t t2;
    fx_res_t t3;
    logic    esc;

    t0 = '0;
    t1 = '0;
    t2 = '0;
    t3 = '0;
    esc = 1'b0;

    state_nxt   = state_r;
    iter_nxt    = iter_r;
    sat_nxt     = sat_r;
    cr_nxt      = cr_r;
    ci_nxt      = ci_r;
    zr_nxt      = zr_r;
    zi_nxt      = zi_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    a2_nxt      = a2_r;
    b2_nxt      = b2_r;
    ax3_nxt     = ax3_r;
    a2x3_nxt    = a2x3_r;
    a3_nxt      = a3_r;
    p_nxt       = p_r;
    r_nxt       = r_r;
    q_nxt       = q_r;
    re_nxt      = re_r;
    im_nxt      = im_r;
    sr_nxt      = sr_r;
    si_nxt      = si_r;
    res_esc_nxt = res_esc_r;
    res_cnt_nxt = res_cnt_r;
    q_pop       = 1'b0;

    // output register drains on ready
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_esc_nxt   = out_esc_r;
    out_cnt_nxt   = out_cnt_r;

    case (state_r)
      ENG_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cr_nxt   = q_item.cr;
          ci_nxt   = q_item.ci;
          zr_nxt   = '0;
          zi_nxt   = '0;
          iter_nxt = '0;
          if (q_item.skip) begin
            res_esc_nxt = 1'b0;
            res_cnt_nxt = iter_limit;
            state_nxt   = ENG_EMIT;
          end else begin
            state_nxt = ENG_ABS;
          end
        end
      end
      ENG_ABS: begin
        t0        = fx_abs(zr_r);
        t1        = fx_abs(zi_r);
        a_nxt     = t0.val;
        b_nxt     = t1.val;
        sat_nxt   = t0.sat | t1.sat;
        state_nxt = ENG_SQ;
      end
      ENG_SQ: begin
        t0        = fx_add(a_r, a_r);
        t1        = fx_add(t0.val, a_r);
        ax3_nxt   = t1.val;
        a2_nxt    = mul0.val;
        b2_nxt    = mul1.val;
        sat_nxt   = sat_r | t0.sat | t1.sat | mul0.sat | mul1.sat;
        state_nxt = ENG_CUBE;
      end
      ENG_CUBE: begin
        t0        = fx_add(a2_r, a2_r);
        t1        = fx_add(t0.val, a2_r);
        a2x3_nxt  = t1.val;
        a3_nxt    = mul0.val;
        p_nxt     = mul1.val;
        r_nxt     = mul2.val;
        sat_nxt   = sat_r | t0.sat | t1.sat | mul0.sat | mul1.sat | mul2.sat;
        state_nxt = ENG_MIX;
      end
      ENG_MIX: begin
        t0        = fx_sub(a3_r, p_r);
        re_nxt    = t0.val;
        q_nxt     = mul0.val;
        sat_nxt   = sat_r | t0.sat | mul0.sat;
        state_nxt = ENG_SUM;
      end
      ENG_SUM: begin
        t0        = fx_sub(q_r, r_r);
        t1        = fx_add(re_r, cr_r);
        im_nxt    = t0.val;
        zr_nxt    = t1.val;
        sat_nxt   = sat_r | t0.sat | t1.sat;
        state_nxt = ENG_IMAG;
      end
      ENG_IMAG: begin
        t0        = fx_add(im_r, ci_r);
        zi_nxt    = t0.val;
        sr_nxt    = mul0.val;
        sat_nxt   = sat_r | t0.sat | mul0.sat;
        state_nxt = ENG_SQI;
      end
      ENG_SQI: begin
        si_nxt    = mul0.val;
        sat_nxt   = sat_r | mul0.sat;
        state_nxt = ENG_TEST;
      end
      ENG_TEST: begin
        // escape test value by mode
        t2 = fx_sub(sr_r, si_r);
        t3 = fx_add(sr_r, si_r);
        case (esc_mode)
          MODE_PROD: t0 = mul0;
          MODE_DIFF: t0 = t2;
          default:   t0 = t3;
        endcase
        esc = sat_r | t0.sat | (t0.val > FX_FOUR);
        if (esc) begin
          res_esc_nxt = 1'b1;
          res_cnt_nxt = iter_r;
          state_nxt   = ENG_EMIT;
        end else if (CNT_W'(iter_r + 1'b1) == iter_limit) begin
          res_esc_nxt = 1'b0;
          res_cnt_nxt = iter_limit;
          state_nxt   = ENG_EMIT;
        end else begin
          iter_nxt  = CNT_W'(iter_r + 1'b1);
          state_nxt = ENG_ABS;
        end
      end
      ENG_EMIT: begin
        // hand the result over once the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_esc_nxt   = res_esc_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = ENG_IDLE;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    sat_r     <= sat_nxt;
    cr_r      <= cr_nxt;
    ci_r      <= ci_nxt;
    zr_r      <= zr_nxt;
    zi_r      <= zi_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    a2_r      <= a2_nxt;
    b2_r      <= b2_nxt;
    ax3_r     <= ax3_nxt;
    a2x3_r    <= a2x3_nxt;
    a3_r      <= a3_nxt;
    p_r       <= p_nxt;
    r_r       <= r_nxt;
    q_r       <= q_nxt;
    re_r      <= re_nxt;
    im_r      <= im_nxt;
    sr_r      <= sr_nxt;
    si_r      <= si_nxt;
    res_esc_r <= res_esc_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_esc_r <= out_esc_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // a popped point either starts iterating or goes straight to the result
  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ENG_ABS || state_r == ENG_EMIT))
    else $error("popped point did not start");

  // the test phase always closes an iteration
  a_test_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_TEST) |=> (state_r == ENG_ABS || state_r == ENG_EMIT))
    else $error("test phase did not resolve");

  // a further iteration advances the index by one
  a_iter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_TEST && state_nxt == ENG_ABS) |=> (iter_r == $past(iter_r) + 1'b1))
    else $error("iteration index skipped");

  // leaving the result phase puts the pending result on the channel
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_EMIT && state_nxt == ENG_IDLE) |=>
      (out_ch.valid && out_ch.escaped == $past(res_esc_r)
        && out_ch.iter_count == $past(res_cnt_r)))
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

// ----- sv/cubic_abs_escape_time_unit.sv -----
// top level of the cubic absolute-value escape-time unit
//
//   channel   direction  payload                            handshake
//   in_ch     in         cr, ci (signed Q5.26)              valid / ready
//   out_ch    out        escaped, iter_count                valid / ready
//   cfg_*     in         cfg_index, cfg_wdata               cfg_we, no wait
//
// each iteration steps the engine's phase sequencer through abs, square, cube, mix,
// sum, imag, square-imag and test around three shared multipliers; with
// max_iterations at 0 a point goes straight from the queue to the result
// reset is synchronous and active low; registers return to 50 and sum mode
// a two-entry queue lets new points enter while the engine works and the
// output register lets the engine finish one point while the result waits
`timescale 1ns / 1ps
`default_nettype none

module cubic_abs_escape_time_unit import caet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  caet_point_if.sink            in_ch,
  caet_result_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]  iter_limit_r;
  logic [CNT_W-1:0]  iter_limit_nxt;
  logic [MODE_W-1:0] esc_mode_r;
  logic [MODE_W-1:0] esc_mode_nxt;

  logic       push;
  caet_item_t push_item;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  caet_item_t q_item;

  // configuration register writes
  always_comb begin
    iter_limit_nxt = iter_limit_r;
    esc_mode_nxt   = esc_mode_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITER: iter_limit_nxt = CNT_W'(cfg_wdata);
        CFG_ESC_MODE: esc_mode_nxt   = cfg_wdata[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= MAX_ITER_RST;
      esc_mode_r   <= ESC_MODE_RST;
    end else begin
      iter_limit_r <= iter_limit_nxt;
      esc_mode_r   <= esc_mode_nxt;
    end
  end

  caet_front u_front (
    .in_ch      (in_ch),
    .iter_limit (iter_limit_r),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  caet_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  caet_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .iter_limit (iter_limit_r),
    .esc_mode   (esc_mode_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for the cubic absolute-value escape-time unit
`timescale 1ns / 1ps

module testbench;
  import caet_pkg::*;

  localparam int DW           = DATA_WIDTH;
  localparam int BLOCK_POINTS = 50;
  localparam int SETTLE       = 4;
  localparam int PRINT_CAP    = 50;

  // unused escape code, runs as the sum test
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef logic signed [IN_W-1:0] coord_t;

  typedef struct packed {
    logic             escaped;
    logic [CNT_W-1:0] iter_count;
  } verdict_t;

  // fixed-point landmarks
  localparam coord_t ONE          = coord_t'(1) << FRAC_BITS;
  localparam int     NEAR_SPAN    = (ONE * 8) / 5;
  localparam int     EDGE_SPAN    = (ONE * 5) / 2;
  localparam fx_t    ESCAPE_BOUND = fx_t'(4) << FRAC_BITS;

  // saturation bounds at the widths used by the predictor
  localparam logic signed [DW:0]     SUM_MAX = FX_MAX;
  localparam logic signed [DW:0]     SUM_MIN = FX_MIN;
  localparam logic signed [63:0]     LOAD_MAX = FX_MAX;
  localparam logic signed [63:0]     LOAD_MIN = FX_MIN;
  localparam logic [2*DW+1:0]        MAG_MAX = {{(DW+3){1'b0}}, {(DW-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  caet_point_if  point_ch ();
  caet_result_if verdict_ch ();

  cubic_abs_escape_time_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (point_ch),
    .out_ch    (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow registers, expected results and run statistics
  logic [CNT_W-1:0]  shadow_iter_limit = MAX_ITER_RST;
  logic [MODE_W-1:0] shadow_mode       = ESC_MODE_RST;
  verdict_t          pending_verdicts[$];
  bit                idle_enable = 1'b1;
  int unsigned       mismatch_count;
  int unsigned       points_sent;
  int unsigned       results_checked;
  int unsigned       escapes_seen;

  always #5 clk = ~clk;

  // saturating fixed-point arithmetic
  function automatic fx_t clip_add(fx_t a, fx_t b, inout logic clipped);
    logic signed [DW:0] wa;
    logic signed [DW:0] wb;
    logic signed [DW:0] s;
    wa = a;
    wb = b;
    s  = wa + wb;
    if (s > SUM_MAX) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    if (s < SUM_MIN) begin
      clipped = 1'b1;
      return FX_MIN;
    end
    return fx_t'(s[DW-1:0]);
  endfunction

  function automatic fx_t clip_sub(fx_t a, fx_t b, inout logic clipped);
    logic signed [DW:0] wa;
    logic signed [DW:0] wb;
    logic signed [DW:0] s;
    wa = a;
    wb = b;
    s  = wa - wb;
    if (s > SUM_MAX) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    if (s < SUM_MIN) begin
      clipped = 1'b1;
      return FX_MIN;
    end
    return fx_t'(s[DW-1:0]);
  endfunction

  function automatic fx_t clip_abs(fx_t a, inout logic clipped);
    if (a == FX_MIN) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    return (a < 0) ? -a : a;
  endfunction

  // exact magnitude product, truncated toward zero, sign restored
  function automatic fx_t clip_mul(fx_t a, fx_t b, inout logic clipped);
    logic signed [DW:0] wa;
    logic signed [DW:0] wb;
    logic [DW:0]        ma;
    logic [DW:0]        mb;
    logic [2*DW+1:0]    q;
    logic               neg;
    wa  = a;
    wb  = b;
    ma  = wa[DW] ? -wa : wa;
    mb  = wb[DW] ? -wb : wb;
    q   = (2*DW+2)'(ma) * (2*DW+2)'(mb);
    q   = q >> FRAC_BITS;
    neg = wa[DW] ^ wb[DW];
    if (!neg && q > MAG_MAX) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    if (neg && q > MAG_MAX + 1) begin
      clipped = 1'b1;
      return FX_MIN;
    end
    return neg ? -fx_t'(q[DW-1:0]) : fx_t'(q[DW-1:0]);
  endfunction

  // clamp a point coordinate into the data path range
  function automatic fx_t clip_input(coord_t v);
    logic signed [63:0] x;
    x = v;
    if (x > LOAD_MAX) return FX_MAX;
    if (x < LOAD_MIN) return FX_MIN;
    return fx_t'(x[DW-1:0]);
  endfunction

  // iterate one point under the shadow registers
  function automatic verdict_t escape_verdict(coord_t cr_in, coord_t ci_in);
    fx_t      cr, ci, zr, zi, a, b, a2, b2, a3, a2x, a3x, t1, t2, t3, re, im, sr, si, test;
    logic     clipped;
    verdict_t v;
    cr = clip_input(cr_in);
    ci = clip_input(ci_in);
    zr = '0;
    zi = '0;
    for (int n = 0; n < int'(shadow_iter_limit); n++) begin
      clipped = 1'b0;
      a   = clip_abs(zr, clipped);
      b   = clip_abs(zi, clipped);
      a2  = clip_mul(a, a, clipped);
      b2  = clip_mul(b, b, clipped);
      a3  = clip_mul(a2, a, clipped);
      t1  = clip_add(a, a, clipped);
      a3x = clip_add(t1, a, clipped);
      t2  = clip_mul(a3x, b2, clipped);
      re  = clip_sub(a3, t2, clipped);
      t1  = clip_add(a2, a2, clipped);
      a2x = clip_add(t1, a2, clipped);
      t2  = clip_mul(a2x, b, clipped);
      t3  = clip_mul(b2, b, clipped);
      im  = clip_sub(t2, t3, clipped);
      zr  = clip_add(re, cr, clipped);
      zi  = clip_add(im, ci, clipped);
      sr  = clip_mul(zr, zr, clipped);
      si  = clip_mul(zi, zi, clipped);
      case (shadow_mode)
        MODE_PROD: test = clip_mul(sr, si, clipped);
        MODE_DIFF: test = clip_sub(sr, si, clipped);
        default:   test = clip_add(sr, si, clipped);
      endcase
      if (clipped || test > ESCAPE_BOUND) begin
        v.escaped    = 1'b1;
        v.iter_count = CNT_W'(n);
        return v;
      end
    end
    v.escaped    = 1'b0;
    v.iter_count = shadow_iter_limit;
    return v;
  endfunction

  // random coordinate: half inside the bounded region, some near its edge, some anywhere or at special values
  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return coord_t'(int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
    if (sel < 8) return coord_t'(int'($urandom_range(0, 2 * EDGE_SPAN)) - EDGE_SPAN);
    if (sel < 9) return coord_t'($urandom);
    case ($urandom_range(0, 5))
      0:       return FX_MAX;
      1:       return FX_MIN;
      2:       return '0;
      3:       return 2 * ONE;
      4:       return -2 * ONE;
      default: return coord_t'(int'($urandom_range(0, 30)) - 15);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch: %s, got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // one point request, with an optional idle burst ahead of it
  task automatic send_point(input coord_t cr, input coord_t ci);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      point_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_ch.valid <= 1'b1;
    point_ch.cr    <= cr;
    point_ch.ci    <= ci;
    do @(posedge clk); while (!point_ch.ready);
    pending_verdicts.push_back(escape_verdict(cr, ci));
    points_sent++;
    @(negedge clk);
  endtask

  // wait until every expected result is back and the engine has settled
  task automatic drain_results();
    point_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ITER) begin
      shadow_iter_limit = value[CNT_W-1:0];
    end else if (idx == CFG_ESC_MODE) begin
      shadow_mode = value[MODE_W-1:0];
    end
    @(negedge clk);
  endtask

  // reset values: 50 iterations, sum test; field extremes and the exact-four boundary
  task automatic test_reset_defaults();
    send_point('0, '0);
    send_point(FX_MAX, FX_MAX);
    send_point(FX_MIN, FX_MIN);
    send_point(FX_MIN, '0);
    send_point('0, FX_MAX);
    send_point(2 * ONE, '0);
    send_point(2 * ONE + 1, '0);
    send_point(-ONE, '0);
    send_point((ONE * 3) / 10, -ONE / 5);
    drain_results();
  endtask

  // no iteration at all
  task automatic test_zero_iterations();
    write_reg(CFG_MAX_ITER, '0);
    send_point(ONE, ONE);
    send_point('0, '0);
    drain_results();
  endtask

  task automatic test_single_iteration();
    write_reg(CFG_MAX_ITER, CFG_DATA_W'(1));
    send_point(2 * ONE + 1, '0);
    send_point(ONE / 2, ONE / 2);
    drain_results();
  endtask

  // product, difference and the unused code, each with an escaping and a slower point
  task automatic test_escape_modes();
    write_reg(CFG_MAX_ITER, CFG_DATA_W'(8));
    write_reg(CFG_ESC_MODE, CFG_DATA_W'(MODE_PROD));
    send_point((ONE * 5) / 2, '0);
    send_point((ONE * 3) / 2, (ONE * 3) / 2);
    drain_results();
    write_reg(CFG_ESC_MODE, CFG_DATA_W'(MODE_DIFF));
    send_point('0, (ONE * 5) / 2);
    send_point((ONE * 5) / 2, ONE / 2);
    drain_results();
    write_reg(CFG_ESC_MODE, CFG_DATA_W'(MODE_SPARE));
    send_point(2 * ONE + 1, '0);
    send_point(ONE / 2, '0);
    drain_results();
  endtask

  // largest iteration limit: two quick escapes and one point that never leaves
  task automatic test_long_run();
    write_reg(CFG_ESC_MODE, CFG_DATA_W'(MODE_SUM));
    write_reg(CFG_MAX_ITER, {CFG_DATA_W{1'b1}});
    send_point(FX_MAX, FX_MAX);
    send_point(3 * ONE, ONE / 2);
    send_point('0, '0);
    drain_results();
  endtask

  // random points in blocks, a fresh iteration limit per block
  task automatic test_random_mode(input logic [MODE_W-1:0] mode, input int blocks);
    write_reg(CFG_ESC_MODE, CFG_DATA_W'(mode));
    repeat (blocks) begin
      write_reg(CFG_MAX_ITER, CFG_DATA_W'($urandom_range(1, 48)));
      repeat (BLOCK_POINTS) send_point(pick_coord(), pick_coord());
      drain_results();
    end
  endtask

  // back-to-back traffic on both sides, random mode per block
  task automatic test_steady_tail(input int blocks);
    idle_enable = 1'b0;
    repeat (blocks) begin
      test_random_mode(MODE_W'($urandom_range(0, 3)), 1);
    end
  endtask

  // result side: ready with random stall bursts
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        verdict_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 6);
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin : verdict_checker
    verdict_t want;
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      results_checked++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no point pending", verdict_ch.iter_count, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_ch.escaped !== want.escaped) begin
          report_mismatch("escaped flag", verdict_ch.escaped, want.escaped);
        end
        if (verdict_ch.iter_count !== want.iter_count) begin
          report_mismatch("iteration index", verdict_ch.iter_count, want.iter_count);
        end
        if (want.escaped) escapes_seen++;
      end
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    point_ch.valid <= 1'b0;
    point_ch.cr    <= '0;
    point_ch.ci    <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_zero_iterations();
    test_single_iteration();
    test_escape_modes();
    test_long_run();
    test_random_mode(MODE_SUM, 6);
    test_random_mode(MODE_PROD, 5);
    test_random_mode(MODE_DIFF, 5);
    test_random_mode(MODE_SPARE, 2);
    test_steady_tail(3);

    drain_results();
    repeat (20) @(negedge clk);
    $display("%0d points sent, %0d results checked, %0d escaped, %0d ran out of iterations",
             points_sent, results_checked, escapes_seen, results_checked - escapes_seen);
    $display("iteration limits 0 to 65535, all four escape codes, stalls on both channels");
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/caet_pkg.sv
sv/caet_point_if.sv
sv/caet_result_if.sv
sv/caet_front.sv
sv/caet_queue.sv
sv/caet_engine.sv
sv/cubic_abs_escape_time_unit.sv
sim/testbench.sv
